// ----- hw/rtl/gn3_pkg.sv -----
// Shared types and constants for the 3D gradient noise block.
`timescale 1ns / 1ps

package gn3_pkg;

    // Op field codes
    localparam logic [1:0] OP_GRAD  = 2'd0;
    localparam logic [1:0] OP_PERM  = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Widest lattice index carried in a queue word (4096-entry tables)
    localparam int CELL_W = 12;
    // Raw position fraction, left aligned in 16 bits
    localparam int FRAC16_W = 16;

    typedef enum logic [1:0] {
        KIND_GRAD,
        KIND_PERM,
        KIND_EVAL
    } item_kind_t;

    // One classified word between front and back
    typedef struct packed {
        item_kind_t                      kind;
        logic [7:0]                      index;
        logic [47:0]                     grad;     // {x, y, z}
        logic [7:0]                      perm;
        logic [2:0][CELL_W-1:0]          lattice;  // [0]=x .. [2]=z
        logic [2:0][FRAC16_W-1:0]        frac;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FADE,
        BK_CORNER,
        BK_LERP,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        back_state_t state;
        logic        pop;
    } back_status_t;

endpackage

// ----- hw/rtl/gn3_front.sv -----
// Front end: decodes an input word and splits positions into cell and fraction.
`timescale 1ns / 1ps

module gn3_front
    import gn3_pkg::*;
(
    input  logic               item_valid,
    input  logic [1:0]         op,
    input  logic [7:0]         table_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [15:0] grad_z,
    input  logic [7:0]         perm_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output entry_t             entry,
    output logic               entry_valid
);

    logic known;

    always_comb
    begin
        entry.index      = table_index;
        entry.grad       = {grad_x, grad_y, grad_z};
        entry.perm       = perm_value;
        // floor(pos / 4096): low bits of the arithmetic shift by 12
        entry.lattice[0] = pos_x[12 +: CELL_W];
        entry.lattice[1] = pos_y[12 +: CELL_W];
        entry.lattice[2] = pos_z[12 +: CELL_W];
        entry.frac[0]    = {pos_x[11:0], 4'b0000};
        entry.frac[1]    = {pos_y[11:0], 4'b0000};
        entry.frac[2]    = {pos_z[11:0], 4'b0000};
        known            = 1'b1;
        entry.kind       = KIND_EVAL;
        unique case (op)
            OP_GRAD: entry.kind = KIND_GRAD;
            OP_PERM: entry.kind = KIND_PERM;
            OP_EVAL: entry.kind = KIND_EVAL;
            default: known = 1'b0;  // unused code: dropped
        endcase
        entry_valid = item_valid && known;
    end

endmodule

// ----- hw/rtl/gn3_queue.sv -----
// Two-entry queue of classified words between front and back.
`timescale 1ns / 1ps

module gn3_queue
    import gn3_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    entry_t     slots_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slots_reg[rd_ptr_reg];
    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

// ----- hw/rtl/gn3_back.sv -----
// Back end: table writes, fade, corner hashing, dot products and blending.
`timescale 1ns / 1ps

module gn3_back
    import gn3_pkg::*;
#(
    parameter int GRADIENT_COUNT = 256,
    parameter int FRACTION_BITS  = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             head,
    input  logic               head_valid,
    output back_status_t       status,
    input  logic               noise_stall,
    output logic               noise_valid,
    output logic signed [15:0] noise_value
);

    localparam int F     = FRACTION_BITS;
    localparam int IW    = $clog2(GRADIENT_COUNT);
    localparam int V_W   = F + 19;          // corner dot / blend values
    localparam int D_W   = F + 2;           // signed corner offset
    localparam int IN_W  = F + 4;           // fade inner factor
    localparam int T_W   = 2 * F + 4;       // w * inner
    localparam int IF_W  = 2 * F + 5;
    localparam int MA_W  = (T_W + 1 > V_W + 1) ? T_W + 1 : V_W + 1;
    localparam int MB_W  = 18;
    localparam int PW    = MA_W + MB_W;
    localparam int FS_W  = PW + 17;
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(32767);
    localparam logic signed [V_W-1:0] SAT_LO = V_W'(-32768);
    localparam logic [IF_W-1:0] ONE_F = IF_W'(1) << F;

    back_state_t state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  axis_reg, axis_next;
    logic [2:0]  corner_reg, corner_next;
    logic [2:0]  lerp_reg, lerp_next;

    logic [IW-1:0]          cell_reg [3];
    logic [F-1:0]           frac_reg [3];
    logic [F:0]             u_reg [3];
    logic [2*F-1:0]         wf2_reg;
    logic [T_W-1:0]         t_reg;
    logic signed [PW-1:0]   acc_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [V_W-1:0]  v_reg [8];
    logic signed [15:0]     res_reg;
    logic                   noise_valid_reg;
    logic signed [15:0]     noise_value_reg;

    logic [47:0]            gmem [GRADIENT_COUNT];
    logic [7:0]             pmem [GRADIENT_COUNT];
    logic [47:0]            g_q;
    logic [7:0]             p_q;

    logic                   pop, g_we, p_we, g_re, p_re, out_load;
    logic [IW-1:0]          waddr, g_raddr, p_raddr;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    logic [F-1:0]           wf;
    logic [IF_W-1:0]        inner_full;
    logic [IN_W-1:0]        inner;
    logic [31:0]            wf2_32;
    logic [FS_W-1:0]        fsum;
    logic signed [D_W-1:0]  d_x, d_y, d_z;
    logic signed [15:0]     gx, gy, gz;
    logic [1:0]             lvl;
    logic signed [V_W-1:0]  vb;
    logic signed [V_W:0]    diff;
    logic signed [V_W-1:0]  lres, rs;
    logic signed [15:0]     sat;

    // fade helpers
    assign wf         = frac_reg[axis_reg];
    assign inner_full = (IF_W'(10) << (2 * F)) + IF_W'(6) * IF_W'(wf2_reg)
                      - ((IF_W'(15) * IF_W'(wf)) << F);
    assign inner      = inner_full[F +: IN_W];
    assign wf2_32     = 32'(wf2_reg);
    assign fsum       = FS_W'(acc_reg) + (FS_W'(prod_reg) << 16);

    // corner offsets: w or w - 1
    assign d_x = corner_reg[0] ? D_W'(IF_W'(frac_reg[0]) - ONE_F) : D_W'(frac_reg[0]);
    assign d_y = corner_reg[1] ? D_W'(IF_W'(frac_reg[1]) - ONE_F) : D_W'(frac_reg[1]);
    assign d_z = corner_reg[2] ? D_W'(IF_W'(frac_reg[2]) - ONE_F) : D_W'(frac_reg[2]);
    assign gx  = g_q[47:32];
    assign gy  = g_q[31:16];
    assign gz  = g_q[15:0];

    // blend levels: x pairs, y pairs, z pair
    assign lvl  = (lerp_reg < 3'd4) ? 2'd0 : ((lerp_reg < 3'd6) ? 2'd1 : 2'd2);
    assign vb   = (lvl == 2'd0) ? v_reg[1] : ((lvl == 2'd1) ? v_reg[2] : v_reg[4]);
    assign diff = (V_W + 1)'(vb) - (V_W + 1)'(v_reg[0]);
    assign lres = v_reg[0] + V_W'(prod_reg >>> F);
    assign rs   = lres >>> F;
    assign sat  = (rs > SAT_HI) ? 16'sh7fff : ((rs < SAT_LO) ? -16'sh8000 : rs[15:0]);

    assign waddr = IW'(head.index);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg + 3'd1;
        axis_next   = axis_reg;
        corner_next = corner_reg;
        lerp_next   = lerp_reg;
        pop         = 1'b0;
        g_we        = 1'b0;
        p_we        = 1'b0;
        g_re        = 1'b0;
        p_re        = 1'b0;
        g_raddr     = IW'(p_q);
        p_raddr     = '0;
        out_load    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cnt_next = '0;
                if (head_valid)
                begin
                    pop  = 1'b1;
                    g_we = (head.kind == KIND_GRAD);
                    p_we = (head.kind == KIND_PERM);
                    if (head.kind == KIND_EVAL)
                    begin
                        state_next = BK_FADE;
                        axis_next  = '0;
                    end
                end
            end
            BK_FADE:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        mul_a = MA_W'(wf);
                        mul_b = MB_W'(wf);
                    end
                    3'd2:
                    begin
                        mul_a = MA_W'(inner);
                        mul_b = MB_W'(wf);
                    end
                    3'd4:
                    begin
                        mul_a = MA_W'(t_reg);
                        mul_b = MB_W'(wf2_32[15:0]);
                    end
                    3'd6:
                    begin
                        mul_a = MA_W'(t_reg);
                        mul_b = MB_W'(wf2_32[31:16]);
                    end
                    3'd7:
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            state_next  = BK_CORNER;
                            corner_next = '0;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            BK_CORNER:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        p_re    = 1'b1;
                        p_raddr = cell_reg[0] + IW'(corner_reg[0]);
                    end
                    3'd1:
                    begin
                        p_re    = 1'b1;
                        p_raddr = IW'(p_q) + cell_reg[1] + IW'(corner_reg[1]);
                    end
                    3'd2:
                    begin
                        p_re    = 1'b1;
                        p_raddr = IW'(p_q) + cell_reg[2] + IW'(corner_reg[2]);
                    end
                    3'd3:
                    begin
                        g_re = 1'b1;
                    end
                    3'd4:
                    begin
                        mul_a = MA_W'(d_x);
                        mul_b = MB_W'(gx);
                    end
                    3'd5:
                    begin
                        mul_a = MA_W'(d_y);
                        mul_b = MB_W'(gy);
                    end
                    3'd6:
                    begin
                        mul_a = MA_W'(d_z);
                        mul_b = MB_W'(gz);
                    end
                    default:
                    begin
                        if (corner_reg == 3'd7)
                        begin
                            state_next = BK_LERP;
                            lerp_next  = '0;
                        end
                        else
                        begin
                            corner_next = corner_reg + 3'd1;
                        end
                    end
                endcase
            end
            BK_LERP:
            begin
                cnt_next = {2'b00, ~cnt_reg[0]};
                if (!cnt_reg[0])
                begin
                    mul_a = MA_W'(diff);
                    mul_b = MB_W'(u_reg[lvl]);
                end
                else
                begin
                    lerp_next = lerp_reg + 3'd1;
                    if (lerp_reg == 3'd6)
                    begin
                        state_next = BK_OUT;
                    end
                end
            end
            BK_OUT:
            begin
                cnt_next = '0;
                if (!noise_valid_reg || !noise_stall)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            cnt_reg         <= '0;
            axis_reg        <= '0;
            corner_reg      <= '0;
            lerp_reg        <= '0;
            noise_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            axis_reg   <= axis_next;
            corner_reg <= corner_next;
            lerp_reg   <= lerp_next;
            if (out_load)
            begin
                noise_valid_reg <= 1'b1;
            end
            else if (!noise_stall)
            begin
                noise_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (out_load)
        begin
            noise_value_reg <= res_reg;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head.kind == KIND_EVAL)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cell_reg[i] <= head.lattice[i][IW-1:0];
                        frac_reg[i] <= head.frac[i][FRAC16_W-1 -: F];
                    end
                end
            end
            BK_FADE:
            begin
                case (cnt_reg)
                    3'd1: wf2_reg <= prod_reg[2*F-1:0];
                    3'd3: t_reg <= prod_reg[T_W-1:0];
                    3'd5: acc_reg <= prod_reg;
                    3'd7: u_reg[axis_reg] <= fsum[3*F +: F+1];
                    default:
                    begin
                    end
                endcase
            end
            BK_CORNER:
            begin
                case (cnt_reg)
                    3'd5: acc_reg <= prod_reg;
                    3'd6: acc_reg <= acc_reg + prod_reg;
                    3'd7:
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            v_reg[i] <= v_reg[i+1];
                        end
                        v_reg[7] <= V_W'(acc_reg + prod_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            BK_LERP:
            begin
                if (cnt_reg[0])
                begin
                    if (lvl == 2'd0)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            v_reg[i] <= v_reg[i+2];
                        end
                        v_reg[6] <= lres;
                        v_reg[7] <= lres;
                    end
                    else if (lvl == 2'd1)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            v_reg[i]   <= v_reg[i+4];
                            v_reg[i+4] <= lres;
                        end
                    end
                    else
                    begin
                        res_reg <= sat;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // gradient table
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            gmem[waddr] <= head.grad;
        end
        if (g_re)
        begin
            g_q <= gmem[g_raddr];
        end
    end

    // permutation table
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[waddr] <= head.perm;
        end
        if (p_re)
        begin
            p_q <= pmem[p_raddr];
        end
    end

    assign status.state = state_reg;
    assign status.pop   = pop;
    assign noise_valid  = noise_valid_reg;
    assign noise_value  = noise_value_reg;

endmodule

// ----- hw/rtl/gradient_noise_3d.sv -----
// Top level of the 3D gradient noise block: front, queue and back.
`timescale 1ns / 1ps

//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------
//  item    | item_valid / item_stall  | op, table_index, grad_x/y/z, perm_value,
//          |                          | pos_x/y/z
//  noise   | noise_valid / noise_stall| noise_value (Q2.14, saturated)
//
//  A load word is written from the back end's idle state; an evaluate word runs
//  the three fades (four passes each through the shared multiplier), the eight
//  corners (three chained permutation reads, one gradient read and three
//  products each) and then the blends: x pairs, then y pairs, then the z pair.
//  Reset clears control state only; tables are undefined until loaded.
//  item_stall rises only while the two-word queue is full; noise_stall holds
//  the result register and stops the back end once a second result is ready.
//  GRADIENT_COUNT is taken as a power of two.

module gradient_noise_3d
    import gn3_pkg::*;
#(
    parameter int GRADIENT_COUNT = 256,
    parameter int FRACTION_BITS  = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         op,
    input  logic [7:0]         table_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [15:0] grad_z,
    input  logic [7:0]         perm_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               noise_valid,
    input  logic               noise_stall,
    output logic signed [15:0] noise_value
);

    entry_t        front_entry;
    logic          front_valid;
    logic          q_push;
    entry_t        q_head;
    queue_status_t q_status;
    back_status_t  b_status;

    // front: decode and split positions, no storage
    gn3_front u_front (
        .item_valid  (item_valid),
        .op          (op),
        .table_index (table_index),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .perm_value  (perm_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .entry       (front_entry),
        .entry_valid (front_valid)
    );

    // a word is taken whenever the queue has room; unused op codes vanish here
    assign item_stall = q_status.full;
    assign q_push     = front_valid && !q_status.full;

    gn3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .pop        (b_status.pop),
        .head       (q_head),
        .status     (q_status)
    );

    // back: executes loads and evaluates in queue order
    gn3_back #(
        .GRADIENT_COUNT (GRADIENT_COUNT),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_valid  (q_status.valid),
        .status      (b_status),
        .noise_stall (noise_stall),
        .noise_valid (noise_valid),
        .noise_value (noise_value)
    );

    // back end never pops an empty queue
    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.pop |-> q_status.valid)
        else $error("back end popped an empty queue");

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue overflow");

    // a new result only appears after the back end reached its output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(noise_valid) |-> $past(b_status.state) == BK_OUT)
        else $error("result appeared outside the output step");

endmodule
